// ===== hdl/swdpc_pkg.sv =====
// Package for the smoothed window dwell pump controller.
// Holds the shared types, register indexes, lighting codes and reset values.
// No dependencies.
package swdpc_pkg;

    localparam int unsigned SampleW  = 10;
    localparam int unsigned TickW    = 16;
    localparam int unsigned AvgW     = 18;
    localparam int unsigned WeightW  = 8;
    localparam int unsigned FlagsW   = 3;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 16;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] RegModeFlags = 3'd0;
    localparam logic [CfgAddrW-1:0] RegWeight    = 3'd1;
    localparam logic [CfgAddrW-1:0] RegOnThr     = 3'd2;
    localparam logic [CfgAddrW-1:0] RegOffThr    = 3'd3;
    localparam logic [CfgAddrW-1:0] RegUpperThr  = 3'd4;
    localparam logic [CfgAddrW-1:0] RegDwell     = 3'd5;
    localparam logic [CfgAddrW-1:0] RegMinIntv   = 3'd6;

    // Mode flag bit positions.
    localparam int unsigned FlagForce = 0;
    localparam int unsigned FlagAuto  = 1;
    localparam int unsigned FlagLight = 2;

    // Lighting codes.
    localparam logic [1:0] LightNormal   = 2'd0;
    localparam logic [1:0] LightWatering = 2'd1;
    localparam logic [1:0] LightWhite    = 2'd2;

    // Register reset values.
    localparam logic [FlagsW-1:0]  RstModeFlags = 3'd6;
    localparam logic [WeightW-1:0] RstWeight    = 8'd230;
    localparam logic [SampleW-1:0] RstOnThr     = 10'd500;
    localparam logic [SampleW-1:0] RstOffThr    = 10'd300;
    localparam logic [SampleW-1:0] RstUpperThr  = 10'd900;
    localparam logic [TickW-1:0]   RstDwell     = 16'd5000;
    localparam logic [TickW-1:0]   RstMinIntv   = 16'd100;

    typedef struct packed {
        logic [FlagsW-1:0]  mode_flags;
        logic [WeightW-1:0] smoothing_weight;
        logic [SampleW-1:0] on_threshold;
        logic [SampleW-1:0] off_threshold;
        logic [SampleW-1:0] upper_threshold;
        logic [TickW-1:0]   dwell_ticks;
        logic [TickW-1:0]   min_interval;
    } t_cfg;

    typedef struct packed {
        logic [AvgW-1:0]  average;
        logic             request;
        logic [TickW-1:0] window_entry_time;
        logic [TickW-1:0] last_processed_time;
        logic             relay_level;
        logic [1:0]       light_code;
    } t_state;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic [TickW-1:0]   timestamp;
    } t_item;

    typedef struct packed {
        logic               processed;
        logic               relay_drive;
        logic [1:0]         led_mode;
        logic [SampleW-1:0] smoothed;
        logic               pump_request;
    } t_result;

endpackage

// ===== hdl/swdpc_step.sv =====
// One controller step: rate limit, relay and light drive, average update and
// dwell window test, all as combinational logic. Depends on swdpc_pkg.
module swdpc_step (
    input  swdpc_pkg::t_cfg    i_cfg,
    input  swdpc_pkg::t_state  i_state,
    input  swdpc_pkg::t_item   i_item,
    output swdpc_pkg::t_state  o_state,
    output swdpc_pkg::t_result o_result
);

    logic [swdpc_pkg::TickW-1:0]   since;
    logic [swdpc_pkg::TickW-1:0]   dwell;
    logic                          take;
    logic                          relay;
    logic [1:0]                    light;
    logic signed [swdpc_pkg::AvgW:0]    diff;
    logic signed [swdpc_pkg::AvgW+9:0]  prod;
    logic signed [swdpc_pkg::AvgW+9:0]  total;
    logic [swdpc_pkg::AvgW-1:0]    avg_new;
    logic [swdpc_pkg::SampleW-1:0] lower;
    logic                          in_window;

    assign since = i_item.timestamp - i_state.last_processed_time;
    assign take  = (since >= i_cfg.min_interval);

    always_comb begin
        if (i_cfg.mode_flags[swdpc_pkg::FlagForce]) begin
            relay = 1'b1;
            light = swdpc_pkg::LightNormal;
        end else if (i_cfg.mode_flags[swdpc_pkg::FlagAuto] && i_state.request) begin
            relay = 1'b1;
            light = swdpc_pkg::LightWatering;
        end else begin
            relay = 1'b0;
            light = swdpc_pkg::LightNormal;
        end
        if (!i_cfg.mode_flags[swdpc_pkg::FlagLight]) begin
            light = swdpc_pkg::LightWhite;
        end
    end

    // avg*w + (x<<8)*(256-w) is rewritten as (x<<16) + (avg - (x<<8))*w so
    // that a single signed multiplier does the blend. The sum is never negative.
    assign diff  = $signed({1'b0, i_state.average}) - $signed({1'b0, i_item.sample, 8'd0});
    assign prod  = diff * $signed({1'b0, i_cfg.smoothing_weight});
    assign total = $signed({2'b00, i_item.sample, 16'd0}) + prod;
    assign avg_new = total[swdpc_pkg::AvgW+7:8];

    assign lower     = i_state.request ? i_cfg.off_threshold : i_cfg.on_threshold;
    assign in_window = (avg_new > {lower, 8'd0}) && (avg_new < {i_cfg.upper_threshold, 8'd0});
    assign dwell     = i_item.timestamp - i_state.window_entry_time;

    always_comb begin
        o_state = i_state;
        if (take) begin
            o_state.last_processed_time = i_item.timestamp;
            o_state.relay_level         = relay;
            o_state.light_code          = light;
            o_state.average             = avg_new;
            if (!in_window) begin
                o_state.window_entry_time = i_item.timestamp;
                o_state.request           = 1'b0;
            end else if (dwell > i_cfg.dwell_ticks) begin
                o_state.request = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.processed    = take;
        o_result.relay_drive  = o_state.relay_level;
        o_result.led_mode     = o_state.light_code;
        o_result.smoothed     = o_state.average[swdpc_pkg::AvgW-1:8];
        o_result.pump_request = o_state.request;
    end

endmodule

// ===== hdl/smoothed_window_dwell_pump_control_unit.sv =====
// Top level of the smoothed window dwell pump controller: stream ports,
// configuration registers, input and result registers. Depends on swdpc_pkg
// and swdpc_step.
//
// Usage. Each input beat on the slave stream carries a 10-bit moisture sample
// and a 16-bit tick timestamp. Every accepted beat yields exactly one result
// beat on the master stream, in order. The result's tuser bit says whether the
// sample passed the rate limit; tdata holds the relay level, lighting code,
// integer part of the smoothed reading and the pump request after the step.
// Registers are written through the plain write port while the block is idle.
//
// Timing. A beat is captured in the input register, the step is worked out
// from it and lands in the result register, from which the result is offered.
// One beat per cycle is sustained while the receiver keeps tready high; the
// rate rests on the combinational state update (one 19x9 multiply-add and
// the window compares) that each sample feeds into the next.
//
// Reset (synchronous, active low) loads the register defaults and clears the
// average, request, timestamps, relay level and lighting code. When the
// receiver stalls, the result register holds, the input register fills, and
// then the slave tready drops until the result beat is taken.
module smoothed_window_dwell_pump_control_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [9:0] sample, [25:10] timestamp
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [0] relay_drive, [2:1] led_mode,
                                         // [12:3] smoothed, [13] pump_request
    output logic        o_m_axis_tuser,  // [0] processed
    input  logic        i_cfg_we,
    input  logic [swdpc_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [swdpc_pkg::CfgDataW-1:0] i_cfg_wdata
);

    swdpc_pkg::t_cfg    r_cfg;
    swdpc_pkg::t_state  r_state;
    swdpc_pkg::t_state  n_state;
    swdpc_pkg::t_item   r_item;
    swdpc_pkg::t_result r_out;
    swdpc_pkg::t_result n_out;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               advance;
    logic               in_fire;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_flags       <= swdpc_pkg::RstModeFlags;
            r_cfg.smoothing_weight <= swdpc_pkg::RstWeight;
            r_cfg.on_threshold     <= swdpc_pkg::RstOnThr;
            r_cfg.off_threshold    <= swdpc_pkg::RstOffThr;
            r_cfg.upper_threshold  <= swdpc_pkg::RstUpperThr;
            r_cfg.dwell_ticks      <= swdpc_pkg::RstDwell;
            r_cfg.min_interval     <= swdpc_pkg::RstMinIntv;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                swdpc_pkg::RegModeFlags:
                    r_cfg.mode_flags <= i_cfg_wdata[swdpc_pkg::FlagsW-1:0];
                swdpc_pkg::RegWeight:
                    r_cfg.smoothing_weight <= i_cfg_wdata[swdpc_pkg::WeightW-1:0];
                swdpc_pkg::RegOnThr:
                    r_cfg.on_threshold <= i_cfg_wdata[swdpc_pkg::SampleW-1:0];
                swdpc_pkg::RegOffThr:
                    r_cfg.off_threshold <= i_cfg_wdata[swdpc_pkg::SampleW-1:0];
                swdpc_pkg::RegUpperThr:
                    r_cfg.upper_threshold <= i_cfg_wdata[swdpc_pkg::SampleW-1:0];
                swdpc_pkg::RegDwell:
                    r_cfg.dwell_ticks <= i_cfg_wdata;
                swdpc_pkg::RegMinIntv:
                    r_cfg.min_interval <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    swdpc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.sample    <= i_s_axis_tdata[9:0];
            r_item.timestamp <= i_s_axis_tdata[25:10];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.processed;
    assign o_m_axis_tdata  = {2'b00, r_out.pump_request, r_out.smoothed,
                              r_out.led_mode, r_out.relay_drive};

`ifndef SYNTHESIS
    // A rate-limited step leaves the controller state untouched.
    a_hold_on_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !n_out.processed) |=> $stable(r_state))
        else $error("state changed on a rate-limited step");

    // With lighting disabled, a processed step always shows the white code.
    a_white_when_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out.processed && !r_cfg.mode_flags[swdpc_pkg::FlagLight])
        |=> (r_out.led_mode == swdpc_pkg::LightWhite))
        else $error("lighting disabled but led code is not white");

    // The slave side only stalls when a beat is already waiting in the input register.
    a_stall_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing pending");

    // The result register is refilled exactly when a pending beat moves on.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("step completed but no result offered");
`endif

endmodule

// ===== dv/swdpc_checker.sv =====
// Checker for the smoothed window dwell pump controller: follows the register
// writes, predicts one result per accepted sample beat and compares results.
// Depends on swdpc_pkg only.
module swdpc_checker
    import swdpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [31:0]         i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [15:0]         i_m_tdata,
    input  logic                i_m_tuser,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_processed
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg    regs;
    t_state  ctrl;
    t_result awaited_results[$];
    int      fail_total;
    int      results_seen;
    int      processed_seen;

    assign o_fail_count = fail_total;
    assign o_results    = results_seen;
    assign o_processed  = processed_seen;

    initial begin
        fail_total     = 0;
        results_seen   = 0;
        processed_seen = 0;
        o_pending      = 0;
    end

    // One controller step: rate limit, relay drive from the held request,
    // average update, then the hysteresis window and dwell test.
    function automatic t_result pump_step(t_item item);
        logic [TickW-1:0]   since_last;
        logic [TickW-1:0]   dwell_elapsed;
        logic [SampleW-1:0] lower_bound;
        logic [31:0]        blend;
        logic               relay;
        logic [1:0]         light;
        logic               in_window;
        t_result            res;
        since_last    = item.timestamp - ctrl.last_processed_time;
        res.processed = (since_last >= regs.min_interval);
        if (res.processed) begin
            ctrl.last_processed_time = item.timestamp;
            if (regs.mode_flags[FlagForce]) begin
                relay = 1'b1;
                light = LightNormal;
            end else if (regs.mode_flags[FlagAuto] && ctrl.request) begin
                relay = 1'b1;
                light = LightWatering;
            end else begin
                relay = 1'b0;
                light = LightNormal;
            end
            if (!regs.mode_flags[FlagLight]) begin
                light = LightWhite;
            end
            ctrl.relay_level = relay;
            ctrl.light_code  = light;

            blend = 32'(ctrl.average) * 32'(regs.smoothing_weight)
                  + (32'(item.sample) << 8) * (32'd256 - 32'(regs.smoothing_weight));
            ctrl.average = blend[AvgW+7:8];

            lower_bound = ctrl.request ? regs.off_threshold : regs.on_threshold;
            in_window = (ctrl.average > {lower_bound, 8'd0})
                     && (ctrl.average < {regs.upper_threshold, 8'd0});
            dwell_elapsed = item.timestamp - ctrl.window_entry_time;
            if (!in_window) begin
                ctrl.window_entry_time = item.timestamp;
                ctrl.request           = 1'b0;
            end else if (dwell_elapsed > regs.dwell_ticks) begin
                ctrl.request = 1'b1;
            end
        end
        res.relay_drive  = ctrl.relay_level;
        res.led_mode     = ctrl.light_code;
        res.smoothed     = ctrl.average[AvgW-1:8];
        res.pump_request = ctrl.request;
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        t_item   item;
        if (!i_rst_n) begin
            regs = '{mode_flags: RstModeFlags, smoothing_weight: RstWeight,
                     on_threshold: RstOnThr, off_threshold: RstOffThr,
                     upper_threshold: RstUpperThr, dwell_ticks: RstDwell,
                     min_interval: RstMinIntv};
            ctrl = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    RegModeFlags: regs.mode_flags       = i_cfg_wdata[FlagsW-1:0];
                    RegWeight:    regs.smoothing_weight = i_cfg_wdata[WeightW-1:0];
                    RegOnThr:     regs.on_threshold     = i_cfg_wdata[SampleW-1:0];
                    RegOffThr:    regs.off_threshold    = i_cfg_wdata[SampleW-1:0];
                    RegUpperThr:  regs.upper_threshold  = i_cfg_wdata[SampleW-1:0];
                    RegDwell:     regs.dwell_ticks      = i_cfg_wdata[TickW-1:0];
                    RegMinIntv:   regs.min_interval     = i_cfg_wdata[TickW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.processed    = i_m_tuser;
                got.relay_drive  = i_m_tdata[0];
                got.led_mode     = i_m_tdata[2:1];
                got.smoothed     = i_m_tdata[12:3];
                got.pump_request = i_m_tdata[13];
                results_seen++;
                if (got.processed === 1'b1) begin
                    processed_seen++;
                end
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, got %h/%b",
                             $time, i_m_tdata, i_m_tuser);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("processed", 16'(want.processed), 16'(got.processed));
                    check_field("relay_drive", 16'(want.relay_drive), 16'(got.relay_drive));
                    check_field("led_mode", 16'(want.led_mode), 16'(got.led_mode));
                    check_field("smoothed", 16'(want.smoothed), 16'(got.smoothed));
                    check_field("pump_request", 16'(want.pump_request),
                                16'(got.pump_request));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                item.sample    = i_s_tdata[SampleW-1:0];
                item.timestamp = i_s_tdata[SampleW+TickW-1:SampleW];
                awaited_results.push_back(pump_step(item));
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ===== dv/smoothed_window_dwell_pump_control_unit_test.sv =====
// Testbench top for the smoothed window dwell pump controller: clock, reset,
// register phases, sample and result stream drivers, watchdog and verdict.
// Depends on swdpc_pkg, swdpc_checker and the block's top level.
module smoothed_window_dwell_pump_control_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import swdpc_pkg::*;

    localparam int ClkHalf       = 6;
    localparam int ResetCycles   = 5;
    localparam int WatchdogLimit = 1000;
    localparam int DrainCycles   = 8;
    localparam int RandomPhases  = 12;
    localparam int CalmPhases    = 2;
    localparam int ItemsPerPhase = 111;
    localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [31:0]         i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [15:0]         o_m_axis_tdata;
    logic                o_m_axis_tuser;
    logic                i_cfg_we;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_wdata;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          processed_seen;
    int          beats_sent;
    int          settings_used;
    int          idle_cycles;
    int          stall_left;
    bit          calm;
    logic [15:0] tick_now;

    always #(ClkHalf) i_clk = ~i_clk;

    smoothed_window_dwell_pump_control_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    swdpc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_processed  (processed_seen)
    );

    // Either extreme now and then, otherwise a value from the useful range.
    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                               int unsigned typ_lo, int unsigned typ_hi);
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return lo;
        end else if (roll == 1) begin
            return hi;
        end
        return $urandom_range(typ_lo, typ_hi);
    endfunction

    // Mostly far enough apart to pass the rate limit, sometimes too close,
    // occasionally an arbitrary jump.
    function automatic logic [15:0] tick_step(int unsigned min_gap);
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 15);
        span = (65535 - min_gap < 200) ? 65535 - min_gap : 200;
        if (roll == 0) begin
            return 16'($urandom);
        end else if (roll < 3) begin
            return 16'($urandom_range(0, min_gap));
        end
        return 16'(min_gap + $urandom_range(0, span));
    endfunction

    // Target moisture level: below the window, above it, in the band that only
    // holds a raised request, or well inside the window.
    function automatic int unsigned choose_level(int unsigned on_thr, int unsigned off_thr,
                                                 int unsigned up_thr);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 3) begin
            return $urandom_range(0, on_thr);
        end else if (roll < 6) begin
            return $urandom_range(up_thr, 1023);
        end else if (roll < 10 && off_thr < on_thr) begin
            return $urandom_range(off_thr + 1, on_thr);
        end else if (on_thr + 1 < up_thr) begin
            return $urandom_range(on_thr + 1, up_thr - 1);
        end
        return $urandom_range(0, 1023);
    endfunction

    task automatic cfg_write(logic [CfgAddrW-1:0] index, logic [CfgDataW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic send_beat(logic [SampleW-1:0] sample, logic [TickW-1:0] stamp);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, stamp, sample};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        beats_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every result has been taken, so that the
    // registers may be rewritten.
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        settings_used++;
    endtask

    // Result side: now and then drops tready for a burst of random length, never while calm.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int unsigned mode_v;
        int unsigned weight_v;
        int unsigned on_v;
        int unsigned off_v;
        int unsigned up_v;
        int unsigned dwell_v;
        int unsigned min_v;
        int unsigned level;
        int          hold_left;
        int          value;
        logic [SampleW-1:0] sample;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        beats_sent      = 0;
        settings_used   = 0;
        idle_cycles     = 0;
        stall_left      = 0;
        calm            = 1'b0;
        hold_left       = 0;
        level           = 0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: rate limit at and just short of the interval, a
        // repeated timestamp and a difference that wraps through zero.
        send_beat(10'd1023, 16'd0);
        send_beat(10'd0, 16'd99);
        send_beat(10'd1023, 16'd100);
        send_beat(10'd512, 16'd100);
        send_beat(10'd1023, 16'd65535);
        send_beat(10'd0, 16'd99);
        tick_now = 16'd99;
        drain();

        // No smoothing, no rate limit, no dwell: the request follows the
        // window at once, holds in the lower band and drops on the bounds.
        cfg_write(RegModeFlags, 16'(3'd6));
        cfg_write(RegWeight, 16'd0);
        cfg_write(RegMinIntv, 16'd0);
        cfg_write(RegDwell, 16'd0);
        i_cfg_we <= 1'b0;
        send_beat(10'd700, tick_now + 16'd1);
        send_beat(10'd700, tick_now + 16'd2);
        send_beat(10'd400, tick_now + 16'd2);
        send_beat(10'd300, tick_now + 16'd3);
        send_beat(10'd700, tick_now + 16'd4);
        send_beat(10'd700, tick_now + 16'd5);
        send_beat(10'd900, tick_now + 16'd6);
        send_beat(10'd1023, tick_now + 16'd7);
        send_beat(10'd0, tick_now + 16'd8);
        send_beat(10'd512, tick_now + 16'd9);
        tick_now = tick_now + 16'd9;
        drain();

        // Forced pump with lighting off, heaviest smoothing, an empty window
        // and the largest interval and dwell.
        cfg_write(RegModeFlags, 16'(3'd1));
        cfg_write(RegWeight, 16'd255);
        cfg_write(RegOnThr, 16'd1023);
        cfg_write(RegOffThr, 16'd0);
        cfg_write(RegUpperThr, 16'd0);
        cfg_write(RegDwell, 16'd65535);
        cfg_write(RegMinIntv, 16'd65535);
        cfg_write(RegUnused, 16'hffff);
        i_cfg_we <= 1'b0;
        send_beat(10'd1023, tick_now + 16'd65535);
        send_beat(10'd0, tick_now + 16'd0);
        send_beat(10'd1023, tick_now + 16'd65534);
        send_beat(10'd0, tick_now + 16'd65534);
        tick_now = tick_now + 16'd65534;
        drain();

        for (int phase = 0; phase < RandomPhases; phase++) begin
            calm     = (phase >= RandomPhases - CalmPhases);
            mode_v   = phase % 8;
            weight_v = pick_value(0, 255, 160, 250);
            on_v     = pick_value(0, 1023, 300, 600);
            off_v    = pick_value(0, 1023, 50, on_v);
            up_v     = pick_value(0, 1023, 700, 1000);
            dwell_v  = pick_value(0, 65535, 0, 3000);
            min_v    = pick_value(0, 65535, 20, 300);
            // Bits above each register's width are filled with noise.
            cfg_write(RegModeFlags, {13'($urandom), 3'(mode_v)});
            cfg_write(RegWeight, {8'($urandom), 8'(weight_v)});
            cfg_write(RegOnThr, {6'($urandom), 10'(on_v)});
            cfg_write(RegOffThr, {6'($urandom), 10'(off_v)});
            cfg_write(RegUpperThr, {6'($urandom), 10'(up_v)});
            cfg_write(RegDwell, 16'(dwell_v));
            cfg_write(RegMinIntv, 16'(min_v));
            cfg_write(RegUnused, 16'($urandom));
            i_cfg_we <= 1'b0;
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (hold_left == 0) begin
                    level     = choose_level(on_v, off_v, up_v);
                    hold_left = $urandom_range(15, 50);
                end
                hold_left--;
                if ($urandom_range(0, 15) == 0) begin
                    sample = 10'($urandom_range(0, 1023));
                end else begin
                    value = int'(level) + int'($urandom_range(0, 32)) - 16;
                    if (value < 0) begin
                        value = 0;
                    end else if (value > 1023) begin
                        value = 1023;
                    end
                    sample = 10'(value);
                end
                tick_now = tick_now + tick_step(min_v);
                send_beat(sample, tick_now);
            end
            drain();
        end

        repeat (DrainCycles) @(posedge i_clk);
        $display("Sent %0d sample beats over %0d register settings; %0d results checked,",
                 beats_sent, settings_used, results_seen);
        $display("%0d of them past the rate limit.", processed_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/swdpc_pkg.sv
hdl/swdpc_step.sv
hdl/smoothed_window_dwell_pump_control_unit.sv
dv/swdpc_checker.sv
dv/smoothed_window_dwell_pump_control_unit_test.sv
